// ----- hdl/ckf_pkg.sv -----
// shared types and constants for the colour-key neighbour fill block
`timescale 1ns / 1ps

package ckf_pkg;

    localparam int PIXEL_W       = 32;
    localparam int WIDTH_W       = 11;
    localparam int HEIGHT_W      = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 32;
    localparam int MAX_WIDTH_DEF = 1024;

    localparam logic [PIXEL_W-1:0]  KEY_RESET    = 32'hFFFF00FF;
    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd1024;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'd1;

    // neighbour slots in the fill window
    localparam int NB_LEFT  = 0;
    localparam int NB_RIGHT = 1;
    localparam int NB_UP    = 2;
    localparam int NB_DOWN  = 3;
    localparam int NB_COUNT = 4;

    typedef enum logic
    {
        OP_PIXEL = 1'b0,
        OP_DRAIN = 1'b1
    } ckf_op_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        REG_KEY    = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2
    } ckf_reg_t;

    typedef struct packed
    {
        logic               operation;
        logic [PIXEL_W-1:0] pixel_in;
    } ckf_in_t;

    typedef struct packed
    {
        logic [PIXEL_W-1:0] pixel_out;
        logic               end_of_row;
        logic               end_of_frame;
    } ckf_out_t;

    typedef struct packed
    {
        logic [PIXEL_W-1:0]                center;
        logic [NB_COUNT-1:0][PIXEL_W-1:0]  nb;
        logic [NB_COUNT-1:0]               ok;
    } ckf_nbr_t;

endpackage

// ----- hdl/ckf_row_ram.sv -----
// one-row line buffer, one write port and one registered write-first read port
`timescale 1ns / 1ps

module ckf_row_ram #(
    parameter int DEPTH = ckf_pkg::MAX_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [$clog2(DEPTH)-1:0]     wr_addr,
    input  logic [ckf_pkg::PIXEL_W-1:0]  wr_data,
    input  logic [$clog2(DEPTH)-1:0]     rd_addr,
    output logic [ckf_pkg::PIXEL_W-1:0]  rd_data
);

    logic [ckf_pkg::PIXEL_W-1:0] row_mem_reg [DEPTH];
    logic [ckf_pkg::PIXEL_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            row_mem_reg[wr_addr] <= wr_data;
        end
        // same-address write is forwarded so the window sees the new value
        if (wr_en && (wr_addr == rd_addr))
        begin
            rd_data_reg <= wr_data;
        end
        else
        begin
            rd_data_reg <= row_mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- hdl/ckf_fill.sv -----
// keyed pixel replacement by the average of its usable neighbours
`timescale 1ns / 1ps

module ckf_fill (
    input  ckf_pkg::ckf_nbr_t             window,
    input  logic [ckf_pkg::PIXEL_W-1:0]   key_color,
    output logic [ckf_pkg::PIXEL_W-1:0]   pixel
);

    localparam logic [9:0] DIV3_MUL   = 10'd683;
    localparam int         DIV3_SHIFT = 11;

    logic [9:0] r_sum;
    logic [9:0] g_sum;
    logic [9:0] b_sum;
    logic [2:0] cnt;

    // truncated sum / cnt for cnt up to four; thirds via reciprocal multiply
    function automatic logic [7:0] chan_avg(input logic [9:0] sum, input logic [2:0] n);
        logic [19:0] prod;
        logic [7:0]  avg;
        prod = 20'(sum) * 20'(DIV3_MUL);
        case (n)
            3'd1:    avg = sum[7:0];
            3'd2:    avg = sum[8:1];
            3'd3:    avg = prod[DIV3_SHIFT+7:DIV3_SHIFT];
            3'd4:    avg = sum[9:2];
            default: avg = 8'd0;
        endcase
        return avg;
    endfunction

    always_comb
    begin
        r_sum = '0;
        g_sum = '0;
        b_sum = '0;
        cnt   = '0;
        for (int i = 0; i < ckf_pkg::NB_COUNT; i++)
        begin
            if (window.ok[i] && (window.nb[i] != key_color))
            begin
                r_sum = r_sum + 10'(window.nb[i][23:16]);
                g_sum = g_sum + 10'(window.nb[i][15:8]);
                b_sum = b_sum + 10'(window.nb[i][7:0]);
                cnt   = cnt + 3'd1;
            end
        end
        if (window.center != key_color)
        begin
            pixel = window.center;
        end
        else if (cnt == 3'd0)
        begin
            pixel = '0;
        end
        else
        begin
            pixel = {8'd0, chan_avg(r_sum, cnt), chan_avg(g_sum, cnt), chan_avg(b_sum, cnt)};
        end
    end

endmodule

// ----- hdl/ckf_out_buf.sv -----
// two-entry output register with skid stage
`timescale 1ns / 1ps

module ckf_out_buf (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  ckf_pkg::ckf_out_t  push_data,
    output logic               full,
    output logic               valid,
    input  logic               stall,
    output ckf_pkg::ckf_out_t  data
);

    logic              out_valid_reg;
    logic              out_valid_next;
    logic              skid_valid_reg;
    logic              skid_valid_next;
    ckf_pkg::ckf_out_t out_reg;
    ckf_pkg::ckf_out_t out_next;
    ckf_pkg::ckf_out_t skid_reg;
    ckf_pkg::ckf_out_t skid_next;
    logic              take;

    assign take = out_valid_reg && !stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_next        = out_reg;
        skid_next       = skid_reg;
        if (skid_valid_reg)
        begin
            // input is held off while the skid beat waits
            if (take)
            begin
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || take)
            begin
                out_next       = push_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = push_data;
                skid_valid_next = 1'b1;
            end
        end
        else if (take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign full  = skid_valid_reg;
    assign valid = out_valid_reg;
    assign data  = out_reg;

endmodule

// ----- hdl/color_key_neighbor_fill_core.sv -----
// top level of the colour-key neighbour fill block
// usage:
//   req channel carries one beat per pixel (operation 0) or drain tick (operation 1);
//   a beat is taken on a rising edge with req_valid high and req_stall low.
//   res channel carries processed pixels in raster order with end-of-row and
//   end-of-frame marks, lagging the input by one row; drain ticks flush the last row.
//   one beat per clock is taken while req_stall is low; each result is registered in
//   the output buffer before it appears on res. row buffers are synchronous rams read
//   one column ahead, so the fill of a pixel is one register-to-register pass.
//   when res is stalled, results go into a two-entry output buffer; req_stall rises
//   only once both entries are occupied.
//   each configuration write sets a registered refresh flag that stalls req while
//   the line buffer window is re-read with the new settings.
//   reset clears counters and output flags and loads register defaults; line buffer
//   contents are left as they are, no clearing pass is run.
`timescale 1ns / 1ps

module color_key_neighbor_fill_core #(
    parameter int MAX_WIDTH = ckf_pkg::MAX_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_stall,
    input  ckf_pkg::ckf_in_t                   req_data,
    output logic                               res_valid,
    input  logic                               res_stall,
    output ckf_pkg::ckf_out_t                  res_data,
    input  logic                               cfg_write,
    input  logic [ckf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ckf_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int CNT_W = $clog2(MAX_WIDTH);
    localparam int EW    = (CNT_W + 1 > ckf_pkg::WIDTH_W) ? CNT_W + 1 : ckf_pkg::WIDTH_W;
    localparam logic [EW-1:0]    MAX_W_E = EW'(MAX_WIDTH);
    localparam logic [CNT_W-1:0] LAST_IDX = CNT_W'(MAX_WIDTH - 1);

    logic [ckf_pkg::PIXEL_W-1:0]  key_reg;
    logic [ckf_pkg::WIDTH_W-1:0]  width_reg;
    logic [ckf_pkg::HEIGHT_W-1:0] height_reg;
    logic                         refresh_reg;

    logic [CNT_W-1:0]             col_reg;
    logic [CNT_W-1:0]             col_next;
    logic [CNT_W-1:0]             drain_reg;
    logic [CNT_W-1:0]             drain_next;
    logic [ckf_pkg::HEIGHT_W-1:0] row_reg;
    logic [ckf_pkg::HEIGHT_W-1:0] row_next;
    logic [ckf_pkg::PIXEL_W-1:0]  last_out_reg;
    logic [ckf_pkg::PIXEL_W-1:0]  last_out_next;

    logic [EW-1:0]                w_eff;
    logic [ckf_pkg::HEIGHT_W-1:0] h_eff;
    logic                         draining;
    logic [CNT_W-1:0]             cur_x;
    logic [CNT_W-1:0]             x_inc;
    logic                         last_col;
    logic                         accept;
    logic                         pix_step;
    logic                         drain_step;
    logic                         emit;
    logic [CNT_W-1:0]             next_x;
    logic [CNT_W-1:0]             right_addr;

    logic [ckf_pkg::PIXEL_W-1:0]  orig_c_rd;
    logic [ckf_pkg::PIXEL_W-1:0]  orig_r_rd;
    logic [ckf_pkg::PIXEL_W-1:0]  proc_rd;
    logic [ckf_pkg::PIXEL_W-1:0]  fill_pix;
    ckf_pkg::ckf_nbr_t            window;
    ckf_pkg::ckf_out_t            push_data;
    logic                         buf_full;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg     <= ckf_pkg::KEY_RESET;
            width_reg   <= ckf_pkg::WIDTH_RESET;
            height_reg  <= ckf_pkg::HEIGHT_RESET;
            refresh_reg <= 1'b1;
        end
        else
        begin
            refresh_reg <= cfg_write;
            if (cfg_write)
            begin
                case (cfg_index)
                    ckf_pkg::REG_KEY:    key_reg    <= cfg_data;
                    ckf_pkg::REG_WIDTH:  width_reg  <= cfg_data[ckf_pkg::WIDTH_W-1:0];
                    ckf_pkg::REG_HEIGHT: height_reg <= cfg_data[ckf_pkg::HEIGHT_W-1:0];
                    default:             ;
                endcase
            end
        end
    end

    always_comb
    begin
        if (width_reg == '0)
        begin
            w_eff = EW'(1);
        end
        else if (EW'(width_reg) > MAX_W_E)
        begin
            w_eff = MAX_W_E;
        end
        else
        begin
            w_eff = EW'(width_reg);
        end
    end

    assign h_eff    = (height_reg == '0) ? ckf_pkg::HEIGHT_W'(1) : height_reg;
    assign draining = (row_reg >= h_eff);
    assign cur_x    = draining ? drain_reg : col_reg;
    assign x_inc    = cur_x + CNT_W'(1);
    assign last_col = ((EW'(cur_x) + EW'(1)) >= w_eff);

    assign req_stall  = buf_full || refresh_reg;
    assign accept     = req_valid && !req_stall;
    assign pix_step   = accept && (req_data.operation == ckf_pkg::OP_PIXEL) && !draining;
    assign drain_step = accept && (req_data.operation == ckf_pkg::OP_DRAIN) && draining;
    assign emit       = (pix_step && (row_reg != '0)) || drain_step;

    always_comb
    begin
        col_next      = col_reg;
        row_next      = row_reg;
        drain_next    = drain_reg;
        last_out_next = last_out_reg;
        if (pix_step)
        begin
            col_next = last_col ? '0 : x_inc;
            if (last_col)
            begin
                row_next = row_reg + ckf_pkg::HEIGHT_W'(1);
            end
        end
        if (emit)
        begin
            last_out_next = fill_pix;
        end
        if (drain_step)
        begin
            if (last_col)
            begin
                drain_next = '0;
                row_next   = '0;
                col_next   = '0;
            end
            else
            begin
                drain_next = x_inc;
            end
        end
    end

    // window for the column the next beat will work on
    assign next_x     = (row_next >= h_eff) ? drain_next : col_next;
    assign right_addr = (next_x == LAST_IDX) ? '0 : next_x + CNT_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            drain_reg    <= '0;
            last_out_reg <= '0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            drain_reg    <= drain_next;
            last_out_reg <= last_out_next;
        end
    end

    // original row is kept twice so centre and right neighbour read together
    ckf_row_ram #(
        .DEPTH (MAX_WIDTH)
    ) u_orig_c (
        .clk     (clk),
        .wr_en   (pix_step),
        .wr_addr (cur_x),
        .wr_data (req_data.pixel_in),
        .rd_addr (next_x),
        .rd_data (orig_c_rd)
    );

    ckf_row_ram #(
        .DEPTH (MAX_WIDTH)
    ) u_orig_r (
        .clk     (clk),
        .wr_en   (pix_step),
        .wr_addr (cur_x),
        .wr_data (req_data.pixel_in),
        .rd_addr (right_addr),
        .rd_data (orig_r_rd)
    );

    ckf_row_ram #(
        .DEPTH (MAX_WIDTH)
    ) u_proc (
        .clk     (clk),
        .wr_en   (emit),
        .wr_addr (cur_x),
        .wr_data (fill_pix),
        .rd_addr (next_x),
        .rd_data (proc_rd)
    );

    always_comb
    begin
        window.center                = orig_c_rd;
        window.nb[ckf_pkg::NB_LEFT]  = last_out_reg;
        window.ok[ckf_pkg::NB_LEFT]  = (cur_x != '0);
        window.nb[ckf_pkg::NB_RIGHT] = orig_r_rd;
        window.ok[ckf_pkg::NB_RIGHT] = !last_col;
        window.nb[ckf_pkg::NB_UP]    = proc_rd;
        window.ok[ckf_pkg::NB_UP]    = (row_reg > ckf_pkg::HEIGHT_W'(1));
        window.nb[ckf_pkg::NB_DOWN]  = req_data.pixel_in;
        window.ok[ckf_pkg::NB_DOWN]  = (req_data.operation == ckf_pkg::OP_PIXEL);
    end

    ckf_fill u_fill (
        .window    (window),
        .key_color (key_reg),
        .pixel     (fill_pix)
    );

    assign push_data.pixel_out    = fill_pix;
    assign push_data.end_of_row   = last_col;
    assign push_data.end_of_frame = drain_step && last_col;

    ckf_out_buf u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (emit),
        .push_data (push_data),
        .full      (buf_full),
        .valid     (res_valid),
        .stall     (res_stall),
        .data      (res_data)
    );

    // a configuration write always blocks the following cycle for the window re-read
    a_cfg_refresh: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write |=> req_stall)
        else $error("no refresh stall after configuration write");

    // back-pressure other than refresh only comes from a held result
    a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
        (req_stall && !refresh_reg) |-> res_valid)
        else $error("input stalled with no result waiting");

    // last drain beat returns all counters to the start of a frame
    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (drain_step && last_col) |=> (row_reg == '0 && col_reg == '0 && drain_reg == '0))
        else $error("counters not cleared after end of frame");

endmodule

// ----- tb/tb_color_key_neighbor_fill_core.sv -----
// self-checking testbench for the colour-key neighbour fill core
`timescale 1ns / 1ps

module tb_color_key_neighbor_fill_core;

    localparam int MAX_W       = ckf_pkg::MAX_WIDTH_DEF;
    localparam int TOTAL_BEATS = 1400;
    localparam int HOLD_FRAME  = 3;
    localparam int LONG_HOLD   = 600;
    localparam int SETTLE      = 4;

    typedef struct packed
    {
        bit                          is_cfg;
        ckf_pkg::ckf_reg_t           reg_sel;
        ckf_pkg::ckf_op_t            op;
        logic [ckf_pkg::PIXEL_W-1:0] value;
        bit                          typed;
        ckf_pkg::ckf_out_t           want;
    } plan_row_t;

    logic                           clk;
    logic                           rst_n     = 1'b0;
    logic                           req_valid = 1'b0;
    logic                           req_stall;
    ckf_pkg::ckf_in_t               req_data  = '0;
    logic                           res_valid;
    logic                           res_stall = 1'b0;
    ckf_pkg::ckf_out_t              res_data;
    logic                           cfg_write = 1'b0;
    logic [ckf_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [ckf_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    // register copies and line stores of the fill predictor
    logic [ckf_pkg::PIXEL_W-1:0]  key_q    = ckf_pkg::KEY_RESET;
    logic [ckf_pkg::WIDTH_W-1:0]  width_q  = ckf_pkg::WIDTH_RESET;
    logic [ckf_pkg::HEIGHT_W-1:0] height_q = ckf_pkg::HEIGHT_RESET;
    bit [ckf_pkg::PIXEL_W-1:0]    src_row  [MAX_W];
    bit [ckf_pkg::PIXEL_W-1:0]    done_row [MAX_W];
    bit [ckf_pkg::PIXEL_W-1:0]    prev_px  = '0;
    int unsigned                  col_q    = 0;
    int unsigned                  row_q    = 0;
    int unsigned                  drain_q  = 0;

    ckf_pkg::ckf_out_t filled_due [$];
    plan_row_t         directed_plan [$];

    int mismatches   = 0;
    int results_seen = 0;
    int beats_sent   = 0;
    int keyed_seen   = 0;
    int frames_done  = 0;
    bit quiet          = 1'b0;
    bit long_hold_req  = 1'b0;
    bit long_hold_done = 1'b0;

    color_key_neighbor_fill_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #40_000_000;
        $display("timed out with %0d filled pixels still due", filled_due.size());
        $display("== FAIL ==");
        $finish;
    end

    function automatic int unsigned span(input int unsigned v, input int unsigned cap);
        if (v == 0)
            return 1;
        return (v > cap) ? cap : v;
    endfunction

    // mostly back to back, some short gaps, the odd long one
    function automatic int idle_cycles();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 60)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [ckf_pkg::PIXEL_W-1:0] pick_pixel(
        input logic [ckf_pkg::PIXEL_W-1:0] key
    );
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return key;
            4: return key ^ (32'h1 << $urandom_range(0, 31));
            5: return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
            default: return $urandom();
        endcase
    endfunction

    function automatic void due_add(input ckf_pkg::ckf_out_t due);
        filled_due.insert(filled_due.size(), due);
    endfunction

    function automatic void plan_add(input plan_row_t row);
        directed_plan.insert(directed_plan.size(), row);
    endfunction

    function automatic logic [ckf_pkg::PIXEL_W-1:0] keyed_fill(
        input logic [ckf_pkg::PIXEL_W-1:0]                        centre,
        input logic [ckf_pkg::NB_COUNT-1:0][ckf_pkg::PIXEL_W-1:0] nb,
        input logic [ckf_pkg::NB_COUNT-1:0]                       ok
    );
        int unsigned r, g, b, n;
        logic [ckf_pkg::PIXEL_W-1:0] avg;
        r = 0;
        g = 0;
        b = 0;
        n = 0;
        avg = centre;
        if (centre == key_q)
        begin
            for (int i = 0; i < ckf_pkg::NB_COUNT; i++)
            begin
                if (ok[i] && nb[i] != key_q)
                begin
                    r += nb[i][23:16];
                    g += nb[i][15:8];
                    b += nb[i][7:0];
                    n++;
                end
            end
            avg = '0;
            if (n != 0)
            begin
                r = r / n;
                g = g / n;
                b = b / n;
                avg[23:16] = r[7:0];
                avg[15:8]  = g[7:0];
                avg[7:0]   = b[7:0];
            end
        end
        return avg;
    endfunction

    // advance the fill predictor by one accepted beat
    task automatic predict_beat(input ckf_pkg::ckf_in_t beat, output bit has_res,
                                output ckf_pkg::ckf_out_t res);
        int unsigned w, h, x;
        bit last;
        bit is_px;
        logic [ckf_pkg::NB_COUNT-1:0][ckf_pkg::PIXEL_W-1:0] nb;
        logic [ckf_pkg::NB_COUNT-1:0]                       ok;
        logic [ckf_pkg::PIXEL_W-1:0]                        centre;
        has_res = 1'b0;
        res = '0;
        x = 0;
        last = 1'b0;
        is_px = (beat.operation == ckf_pkg::OP_PIXEL);
        w = span(width_q, MAX_W);
        h = span(height_q, 65535);
        if (is_px)
        begin
            if (row_q < h)
            begin
                x = col_q % MAX_W;
                last = (x + 1 >= w);
                col_q = last ? 0 : x + 1;
                if (row_q == 0)
                begin
                    // first row only fills the line store
                    src_row[x] = beat.pixel_in;
                    if (last)
                        row_q++;
                end
                else
                    has_res = 1'b1;
            end
        end
        else if (row_q >= h)
        begin
            x = drain_q % MAX_W;
            last = (x + 1 >= w);
            has_res = 1'b1;
        end
        if (has_res)
        begin
            nb[ckf_pkg::NB_LEFT]  = prev_px;
            ok[ckf_pkg::NB_LEFT]  = (x > 0);
            nb[ckf_pkg::NB_RIGHT] = last ? '0 : src_row[(x + 1) % MAX_W];
            ok[ckf_pkg::NB_RIGHT] = !last;
            nb[ckf_pkg::NB_UP]    = done_row[x];
            ok[ckf_pkg::NB_UP]    = (row_q > 1);
            nb[ckf_pkg::NB_DOWN]  = beat.pixel_in;
            ok[ckf_pkg::NB_DOWN]  = is_px;
            centre = src_row[x];
            if (centre == key_q)
                keyed_seen++;
            res.pixel_out    = keyed_fill(centre, nb, ok);
            res.end_of_row   = last;
            res.end_of_frame = last && !is_px;
            done_row[x] = res.pixel_out;
            prev_px = res.pixel_out;
            if (is_px)
            begin
                src_row[x] = beat.pixel_in;
                if (last)
                    row_q++;
            end
            else if (last)
            begin
                drain_q = 0;
                row_q = 0;
                col_q = 0;
                frames_done++;
            end
            else
                drain_q = x + 1;
        end
    endtask

    task automatic flag_mismatch(input string what, input logic [ckf_pkg::PIXEL_W-1:0] got,
                                 input logic [ckf_pkg::PIXEL_W-1:0] want);
        mismatches++;
        $display("mismatch at result beat %0d: %s got %h want %h",
                 results_seen, what, got, want);
    endtask

    task automatic check_beat(input ckf_pkg::ckf_out_t got);
        ckf_pkg::ckf_out_t want;
        results_seen++;
        if (filled_due.size() == 0)
            flag_mismatch("beat with nothing due, pixel_out", got.pixel_out, '0);
        else
        begin
            want = filled_due.pop_front();
            if (got.pixel_out !== want.pixel_out)
                flag_mismatch("pixel_out", got.pixel_out, want.pixel_out);
            if (got.end_of_row !== want.end_of_row)
                flag_mismatch("end_of_row", 32'(got.end_of_row), 32'(want.end_of_row));
            if (got.end_of_frame !== want.end_of_frame)
                flag_mismatch("end_of_frame", 32'(got.end_of_frame), 32'(want.end_of_frame));
        end
    endtask

    task automatic send_beat(input ckf_pkg::ckf_op_t op,
                             input logic [ckf_pkg::PIXEL_W-1:0] px,
                             input bit typed, input ckf_pkg::ckf_out_t want);
        ckf_pkg::ckf_in_t  beat;
        ckf_pkg::ckf_out_t due;
        bit                has_res;
        int                gap;
        beat.operation = op;
        beat.pixel_in  = px;
        gap = idle_cycles();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= beat;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        beats_sent++;
        predict_beat(beat, has_res, due);
        if (typed)
            due = want;
        if (has_res || typed)
            due_add(due);
    endtask

    task automatic wait_all_filled();
        req_valid <= 1'b0;
        while (filled_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input ckf_pkg::ckf_reg_t idx,
                             input logic [ckf_pkg::CFG_DATA_W-1:0] val);
        wait_all_filled();
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_write <= 1'b0;
        case (idx)
            ckf_pkg::REG_KEY:    key_q    = val;
            ckf_pkg::REG_WIDTH:  width_q  = val[ckf_pkg::WIDTH_W-1:0];
            ckf_pkg::REG_HEIGHT: height_q = val[ckf_pkg::HEIGHT_W-1:0];
            default:             ;
        endcase
    endtask

    function automatic plan_row_t cfg_row(input ckf_pkg::ckf_reg_t idx,
                                          input logic [ckf_pkg::PIXEL_W-1:0] val);
        plan_row_t row;
        row = '0;
        row.is_cfg  = 1'b1;
        row.reg_sel = idx;
        row.value   = val;
        return row;
    endfunction

    function automatic plan_row_t beat_row(input ckf_pkg::ckf_op_t op,
                                           input logic [ckf_pkg::PIXEL_W-1:0] px);
        plan_row_t row;
        row = '0;
        row.op    = op;
        row.value = px;
        return row;
    endfunction

    function automatic plan_row_t typed_row(input ckf_pkg::ckf_op_t op,
                                            input logic [ckf_pkg::PIXEL_W-1:0] px,
                                            input logic [ckf_pkg::PIXEL_W-1:0] want_px,
                                            input bit eor, input bit eof);
        plan_row_t row;
        row = beat_row(op, px);
        row.typed = 1'b1;
        row.want.pixel_out    = want_px;
        row.want.end_of_row   = eor;
        row.want.end_of_frame = eof;
        return row;
    endfunction

    initial
    begin : result_side
        int hold;
        hold = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (res_valid && !res_stall)
                check_beat(res_data);
            if (long_hold_req && !long_hold_done)
            begin
                // long back-pressure so the block fills and stalls its input
                hold = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            if (hold > 0)
            begin
                res_stall <= 1'b1;
                hold--;
            end
            else
            begin
                res_stall <= 1'b0;
                hold = idle_cycles();
            end
        end
    end

    initial
    begin : stimulus
        int unsigned w_eff, h_eff;
        int frame;
        logic [ckf_pkg::PIXEL_W-1:0]  key_sel;
        logic [ckf_pkg::WIDTH_W-1:0]  w_reg;
        logic [ckf_pkg::HEIGHT_W-1:0] h_reg;

        // zero width and height count as one; key at reset value
        plan_add(cfg_row(ckf_pkg::REG_WIDTH, 32'd0));
        plan_add(cfg_row(ckf_pkg::REG_HEIGHT, 32'd0));
        plan_add(beat_row(ckf_pkg::OP_DRAIN, 32'h5555_5555));
        plan_add(beat_row(ckf_pkg::OP_PIXEL, ckf_pkg::KEY_RESET));
        plan_add(beat_row(ckf_pkg::OP_PIXEL, 32'h1234_5678));
        plan_add(typed_row(ckf_pkg::OP_DRAIN, 32'h0, 32'h0, 1'b1, 1'b1));
        plan_add(beat_row(ckf_pkg::OP_PIXEL, 32'hFFFF_FFFF));
        plan_add(typed_row(ckf_pkg::OP_DRAIN, 32'h0, 32'hFFFF_FFFF, 1'b1, 1'b1));
        // all-zero key on a 3x2 frame
        plan_add(cfg_row(ckf_pkg::REG_KEY, 32'h0));
        plan_add(cfg_row(ckf_pkg::REG_WIDTH, 32'd3));
        plan_add(cfg_row(ckf_pkg::REG_HEIGHT, 32'd2));
        plan_add(beat_row(ckf_pkg::OP_PIXEL, 32'h0));
        plan_add(beat_row(ckf_pkg::OP_PIXEL, 32'h00FF_00FF));
        plan_add(beat_row(ckf_pkg::OP_PIXEL, 32'h0));
        plan_add(beat_row(ckf_pkg::OP_PIXEL, 32'hFFFF_FFFF));
        plan_add(typed_row(ckf_pkg::OP_PIXEL, 32'h0, 32'h00FF_00FF, 1'b0, 1'b0));
        plan_add(beat_row(ckf_pkg::OP_PIXEL, 32'h8080_8080));
        plan_add(beat_row(ckf_pkg::OP_DRAIN, 32'h0));
        plan_add(beat_row(ckf_pkg::OP_DRAIN, 32'h0));
        plan_add(beat_row(ckf_pkg::OP_DRAIN, 32'h0));
        // all-ones key, tallest frame, width cut mid-row, height cut mid-frame
        plan_add(cfg_row(ckf_pkg::REG_KEY, 32'hFFFF_FFFF));
        plan_add(cfg_row(ckf_pkg::REG_WIDTH, 32'd4));
        plan_add(cfg_row(ckf_pkg::REG_HEIGHT, 32'hFFFF));
        plan_add(beat_row(ckf_pkg::OP_PIXEL, 32'hFFFF_FFFF));
        plan_add(beat_row(ckf_pkg::OP_PIXEL, 32'h0102_0304));
        plan_add(beat_row(ckf_pkg::OP_PIXEL, 32'hFFFF_FFFF));
        plan_add(cfg_row(ckf_pkg::REG_WIDTH, 32'd2));
        plan_add(beat_row(ckf_pkg::OP_PIXEL, 32'hFFFF_FFFF));
        plan_add(beat_row(ckf_pkg::OP_PIXEL, 32'h0));
        plan_add(typed_row(ckf_pkg::OP_PIXEL, 32'h7F7F_7F7F, 32'h0102_0304, 1'b1, 1'b0));
        plan_add(beat_row(ckf_pkg::OP_DRAIN, 32'h0));
        plan_add(cfg_row(ckf_pkg::REG_HEIGHT, 32'd2));
        plan_add(beat_row(ckf_pkg::OP_PIXEL, 32'hAAAA_AAAA));
        plan_add(typed_row(ckf_pkg::OP_DRAIN, 32'h0, 32'h0, 1'b0, 1'b0));
        plan_add(typed_row(ckf_pkg::OP_DRAIN, 32'h0, 32'h7F7F_7F7F, 1'b1, 1'b1));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_plan[i])
        begin
            if (directed_plan[i].is_cfg)
                write_reg(directed_plan[i].reg_sel, directed_plan[i].value);
            else
                send_beat(directed_plan[i].op, directed_plan[i].value,
                          directed_plan[i].typed, directed_plan[i].want);
        end

        for (frame = 0; beats_sent < TOTAL_BEATS; frame++)
        begin
            quiet = ($urandom_range(0, 4) == 0);
            if (frame == HOLD_FRAME)
            begin
                // steady stream while the receiver holds off for a long stretch
                quiet = 1'b1;
                w_reg = 11'd24;
                h_reg = 16'd3;
            end
            else
            begin
                case ($urandom_range(0, 19))
                    0:       w_reg = '0;
                    1, 2:    w_reg = 11'($urandom_range(17, 64));
                    default: w_reg = 11'($urandom_range(1, 16));
                endcase
                h_reg = ($urandom_range(0, 19) == 0) ? '0 : 16'($urandom_range(1, 5));
            end
            write_reg(ckf_pkg::REG_WIDTH, 32'(w_reg));
            write_reg(ckf_pkg::REG_HEIGHT, 32'(h_reg));
            if (frame == 0 || $urandom_range(0, 1) != 0)
            begin
                case ($urandom_range(0, 5))
                    0:       key_sel = ckf_pkg::KEY_RESET;
                    1:       key_sel = 32'h0;
                    2:       key_sel = 32'hFFFF_FFFF;
                    default: key_sel = $urandom();
                endcase
                write_reg(ckf_pkg::REG_KEY, key_sel);
            end
            w_eff = span(w_reg, MAX_W);
            h_eff = span(h_reg, 65535);
            for (int r = 0; r < h_eff; r++)
            begin
                for (int c = 0; c < w_eff; c++)
                begin
                    if (frame == HOLD_FRAME && r == 1 && c == 0)
                        long_hold_req = 1'b1;
                    // drain ticks before the frame is complete are dropped
                    if ($urandom_range(0, 99) == 0)
                        send_beat(ckf_pkg::OP_DRAIN, $urandom(), 1'b0, '0);
                    if (!quiet && $urandom_range(0, 299) == 0)
                        wait_all_filled();
                    send_beat(ckf_pkg::OP_PIXEL, pick_pixel(key_q), 1'b0, '0);
                end
            end
            // a stray pixel while the frame waits for its drain
            if ($urandom_range(0, 3) == 0)
                send_beat(ckf_pkg::OP_PIXEL, $urandom(), 1'b0, '0);
            for (int c = 0; c < w_eff; c++)
                send_beat(ckf_pkg::OP_DRAIN, $urandom(), 1'b0, '0);
        end

        wait_all_filled();
        $display("drove %0d beats: %0d directed rows, %0d random frames incl. one long hold",
                 beats_sent, directed_plan.size(), frame);
        $display("checked %0d filled pixels (%0d keyed centres) over %0d frames, %0d mismatches",
                 results_seen, keyed_seen, frames_done, mismatches);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
